// ===== src/mma_pkg.sv =====
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate package
// Shared field widths, request codes, register indexes, controller states
// and the control bundle passed from the controller to the datapath.
// ----------------------------------------------------------------------------
package mma_pkg;

	// Fixed field widths of the request, response and configuration channels.
	localparam int IDX_W   = 4;
	localparam int CFG_W   = 5;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// Reset value of the three dimension registers.
	localparam logic [CFG_W-1:0] DIM_RESET = 5'd16;

	// Request codes.
	typedef enum logic [1:0] {
		ACT_WRITE_A   = 2'd0,
		ACT_WRITE_B   = 2'd1,
		ACT_PRELOAD_C = 2'd2,
		ACT_COMPUTE   = 2'd3
	} action_t;

	// Configuration register indexes (byte address is four times the index).
	typedef enum logic [1:0] {
		REG_ROWS_OF_A    = 2'd0,
		REG_INNER_DIM    = 2'd1,
		REG_COLS_OF_C    = 2'd2,
		REG_B_TRANSPOSED = 2'd3
	} reg_idx_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_MAC,
		ST_DONE
	} state_t;

	// Source of the data written into the C store.
	typedef enum logic [1:0] {
		CSRC_CLEAR,
		CSRC_PRELOAD,
		CSRC_RESULT
	} csrc_t;

	// Datapath control bundle.
	typedef struct packed {
		logic load_acc;
		logic mul_en;
		logic add_en;
	} dp_ctl_t;

endpackage

// ===== src/matrix_multiply_accumulate.sv =====
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate
// Computes single elements of C += A*B (or A*B transposed) out of on-chip
// operand and accumulator stores.
// ----------------------------------------------------------------------------
// Write, preload and ignored requests are taken straight away in the idle
// state. A compute request is accepted, then holds the request channel
// through a load state for the C element, one multiply-accumulate per term of
// min(inner_dim, MAX_DIM) through the single registered multiplier, a drain of
// the read and multiply stages, and a write-back that also fills the result
// register. With an empty inner dimension there is nothing to drain and the
// hold is just load, an idle pass of the loop and write-back. A result waiting
// in that register does not block further requests; only a second write-back
// waits for it. After reset the C store is cleared one entry per cycle, all
// (2**clog2(MAX_DIM))**2 entries (256 at the default size), before the first
// request is taken; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate #(
	parameter int MAX_DIM       = 16,
	parameter int OPERAND_WIDTH = 16,
	parameter int ACCUM_WIDTH   = 48
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration port.
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mma_pkg::PADDR_W-1:0]         paddr,
	input  logic [mma_pkg::PDATA_W-1:0]         pwdata,
	output logic [mma_pkg::PDATA_W-1:0]         prdata,
	output logic                                pready,
	// Request channel.
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [1:0]                          action,
	input  logic [mma_pkg::IDX_W-1:0]           row,
	input  logic [mma_pkg::IDX_W-1:0]           col,
	input  logic signed [OPERAND_WIDTH-1:0]     operand_value,
	input  logic signed [ACCUM_WIDTH-1:0]       accum_value,
	// Response channel.
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic [mma_pkg::IDX_W-1:0]           out_row,
	output logic [mma_pkg::IDX_W-1:0]           out_col,
	output logic signed [ACCUM_WIDTH-1:0]       result,
	output logic                                saturated
);

	import mma_pkg::*;

	localparam int IW = $clog2(MAX_DIM);
	localparam int OD = 2 * (2 ** (2 * IW));
	localparam int CD = 2 ** (2 * IW);

	logic [CFG_W-1:0]   rows_of_a_q, inner_dim_q, cols_of_c_q;
	logic               b_transposed_q;
	logic               cfg_wr;
	reg_idx_t           cfg_idx;

	logic               op_we, c_we, finish, out_busy;
	logic [2*IW:0]      op_waddr, op_raddr_a, op_raddr_b;
	logic [2*IW-1:0]    c_waddr, c_raddr;
	logic [ACCUM_WIDTH-1:0] c_wdata, c_rdata, dp_result;
	logic [OPERAND_WIDTH-1:0] a_rdata, b_rdata;
	logic               dp_sat;
	csrc_t              c_src;
	dp_ctl_t            dp_ctl;
	logic [IDX_W-1:0]   cur_row, cur_col;

	logic               res_valid_q, saturated_q;
	logic [IDX_W-1:0]   out_row_q, out_col_q;
	logic [ACCUM_WIDTH-1:0] result_q;

	// Configuration registers.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_of_a_q    <= DIM_RESET;
			inner_dim_q    <= DIM_RESET;
			cols_of_c_q    <= DIM_RESET;
			b_transposed_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_ROWS_OF_A:    rows_of_a_q    <= pwdata[CFG_W-1:0];
				REG_INNER_DIM:    inner_dim_q    <= pwdata[CFG_W-1:0];
				REG_COLS_OF_C:    cols_of_c_q    <= pwdata[CFG_W-1:0];
				REG_B_TRANSPOSED: b_transposed_q <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (cfg_idx)
			REG_ROWS_OF_A:    prdata = PDATA_W'(rows_of_a_q);
			REG_INNER_DIM:    prdata = PDATA_W'(inner_dim_q);
			REG_COLS_OF_C:    prdata = PDATA_W'(cols_of_c_q);
			REG_B_TRANSPOSED: prdata = PDATA_W'(b_transposed_q);
			default:          prdata = '0;
		endcase
	end

	// Sequencer.
	assign out_busy = res_valid_q && res_stall;

	mma_ctrl #(
		.MAX_DIM (MAX_DIM)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.action       (action),
		.row          (row),
		.col          (col),
		.rows_of_a    (rows_of_a_q),
		.inner_dim    (inner_dim_q),
		.cols_of_c    (cols_of_c_q),
		.b_transposed (b_transposed_q),
		.out_busy     (out_busy),
		.op_we        (op_we),
		.op_waddr     (op_waddr),
		.op_raddr_a   (op_raddr_a),
		.op_raddr_b   (op_raddr_b),
		.c_we         (c_we),
		.c_waddr      (c_waddr),
		.c_raddr      (c_raddr),
		.c_src        (c_src),
		.dp_ctl       (dp_ctl),
		.finish       (finish),
		.cur_row      (cur_row),
		.cur_col      (cur_col)
	);

	// Operand store holding A and B.
	mma_ram #(
		.WIDTH (OPERAND_WIDTH),
		.DEPTH (OD)
	) u_op_ram (
		.clk     (clk),
		.we      (op_we),
		.waddr   (op_waddr),
		.wdata   (operand_value),
		.raddr_a (op_raddr_a),
		.rdata_a (a_rdata),
		.raddr_b (op_raddr_b),
		.rdata_b (b_rdata)
	);

	// Write data for the C store.
	always_comb begin
		case (c_src)
			CSRC_CLEAR:   c_wdata = '0;
			CSRC_PRELOAD: c_wdata = accum_value;
			CSRC_RESULT:  c_wdata = dp_result;
			default:      c_wdata = '0;
		endcase
	end

	// Accumulator store holding C.
	mma_ram #(
		.WIDTH (ACCUM_WIDTH),
		.DEPTH (CD)
	) u_c_ram (
		.clk     (clk),
		.we      (c_we),
		.waddr   (c_waddr),
		.wdata   (c_wdata),
		.raddr_a (c_raddr),
		.rdata_a (c_rdata),
		.raddr_b (c_raddr),
		.rdata_b ()
	);

	// Multiply, accumulate and saturate.
	mma_dp #(
		.MAX_DIM       (MAX_DIM),
		.OPERAND_WIDTH (OPERAND_WIDTH),
		.ACCUM_WIDTH   (ACCUM_WIDTH)
	) u_dp (
		.clk       (clk),
		.dp_ctl    (dp_ctl),
		.a_data    (a_rdata),
		.b_data    (b_rdata),
		.c_data    (c_rdata),
		.result    (dp_result),
		.saturated (dp_sat)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (finish) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_row_q   <= cur_row;
			out_col_q   <= cur_col;
			result_q    <= dp_result;
			saturated_q <= dp_sat;
		end
	end

	assign res_valid = res_valid_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign result    = result_q;
	assign saturated = saturated_q;

endmodule

// ===== src/mma_ram.sv =====
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module mma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read ports.
	always_ff @(posedge clk) begin
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ===== src/mma_ctrl.sv =====
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate controller
// Decodes requests, sequences the C clearing pass and the dot product loop,
// and generates all memory addresses and datapath controls.
// ----------------------------------------------------------------------------
module mma_ctrl #(
	parameter int MAX_DIM = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [1:0]                        action,
	input  logic [mma_pkg::IDX_W-1:0]         row,
	input  logic [mma_pkg::IDX_W-1:0]         col,
	input  logic [mma_pkg::CFG_W-1:0]         rows_of_a,
	input  logic [mma_pkg::CFG_W-1:0]         inner_dim,
	input  logic [mma_pkg::CFG_W-1:0]         cols_of_c,
	input  logic                              b_transposed,
	input  logic                              out_busy,
	output logic                              op_we,
	output logic [2*$clog2(MAX_DIM):0]        op_waddr,
	output logic [2*$clog2(MAX_DIM):0]        op_raddr_a,
	output logic [2*$clog2(MAX_DIM):0]        op_raddr_b,
	output logic                              c_we,
	output logic [2*$clog2(MAX_DIM)-1:0]      c_waddr,
	output logic [2*$clog2(MAX_DIM)-1:0]      c_raddr,
	output mma_pkg::csrc_t                    c_src,
	output mma_pkg::dp_ctl_t                  dp_ctl,
	output logic                              finish,
	output logic [mma_pkg::IDX_W-1:0]         cur_row,
	output logic [mma_pkg::IDX_W-1:0]         cur_col
);

	import mma_pkg::*;

	localparam int IW = $clog2(MAX_DIM);
	localparam int CW = 2 * IW;

	state_t          state_q, state_d;
	logic [IW:0]     k_q;
	logic [CW-1:0]   clr_q;
	logic [IDX_W-1:0] row_q, col_q;
	logic            vld_s1, vld_s2;
	logic            fire, in_store, in_use, issue;
	logic [IW-1:0]   row_i, col_i, row_c, col_c, k_i;

	assign row_i = IW'(row);
	assign col_i = IW'(col);
	assign row_c = IW'(row_q);
	assign col_c = IW'(col_q);
	assign k_i   = k_q[IW-1:0];

	// Request decode.
	assign fire     = (state_q == ST_IDLE) && req_valid;
	assign in_store = (32'(row) < MAX_DIM) && (32'(col) < MAX_DIM);
	assign in_use   = (32'(row) < 32'(rows_of_a)) && (32'(col) < 32'(cols_of_c));

	// One term of the dot product is issued per cycle while terms remain.
	assign issue = (state_q == ST_MAC) && (32'(k_q) < MAX_DIM) &&
		(32'(k_q) < 32'(inner_dim));

	// Operand store: A in the lower half, B in the upper half.
	assign op_waddr   = {action == ACT_WRITE_B, row_i, col_i};
	assign op_raddr_a = {1'b0, row_c, k_i};
	assign op_raddr_b = b_transposed ? {1'b1, col_c, k_i} : {1'b1, k_i, col_c};
	assign op_we      = fire && in_store &&
		(action == ACT_WRITE_A || action == ACT_WRITE_B);

	// The C element is read at acceptance so it is ready in the load cycle.
	assign c_raddr = {row_i, col_i};

	assign cur_row = row_q;
	assign cur_col = col_q;

	// Next state and outputs.
	always_comb begin
		state_d          = state_q;
		req_stall        = 1'b1;
		c_we             = 1'b0;
		c_waddr          = {row_i, col_i};
		c_src            = CSRC_PRELOAD;
		finish           = 1'b0;
		dp_ctl.load_acc  = 1'b0;
		dp_ctl.mul_en    = vld_s1;
		dp_ctl.add_en    = vld_s2;
		unique case (state_q)
			ST_CLEAR: begin
				c_we    = 1'b1;
				c_waddr = clr_q;
				c_src   = CSRC_CLEAR;
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_stall = 1'b0;
				c_we      = fire && in_store && (action == ACT_PRELOAD_C);
				if (fire && in_store && in_use && (action == ACT_COMPUTE)) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				dp_ctl.load_acc = 1'b1;
				state_d         = ST_MAC;
			end
			ST_MAC: begin
				if (!issue && !vld_s1 && !vld_s2) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				c_waddr = {row_c, col_c};
				c_src   = CSRC_RESULT;
				if (!out_busy) begin
					finish  = 1'b1;
					c_we    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register, loop counter and issue pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			k_q     <= '0;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			vld_s2  <= vld_s1;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_IDLE) begin
				k_q <= '0;
			end else if (issue) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// Indices of the request in progress.
	always_ff @(posedge clk) begin
		if (fire) begin
			row_q <= row;
			col_q <= col;
		end
	end

endmodule

// ===== src/mma_dp.sv =====
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate datapath
// Registered signed multiplier, wide exact accumulator and final saturation
// of the sum to the C element range.
// ----------------------------------------------------------------------------
module mma_dp #(
	parameter int MAX_DIM       = 16,
	parameter int OPERAND_WIDTH = 16,
	parameter int ACCUM_WIDTH   = 48
) (
	input  logic                   clk,
	input  mma_pkg::dp_ctl_t       dp_ctl,
	input  logic [OPERAND_WIDTH-1:0] a_data,
	input  logic [OPERAND_WIDTH-1:0] b_data,
	input  logic [ACCUM_WIDTH-1:0] c_data,
	output logic [ACCUM_WIDTH-1:0] result,
	output logic                   saturated
);

	import mma_pkg::*;

	localparam int IW  = $clog2(MAX_DIM);
	localparam int PW  = 2 * OPERAND_WIDTH;
	localparam int MW  = (PW > ACCUM_WIDTH) ? PW : ACCUM_WIDTH;
	localparam int SW  = MW + IW + 2;
	localparam int TW  = SW - ACCUM_WIDTH + 1;

	localparam logic [ACCUM_WIDTH-1:0] POS_MAX = {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
	localparam logic [ACCUM_WIDTH-1:0] NEG_MIN = {1'b1, {(ACCUM_WIDTH-1){1'b0}}};

	logic signed [PW-1:0] prod_s2;
	logic signed [SW-1:0] acc_q;
	logic [TW-1:0]        top_bits;

	// Product of one A and one B element.
	always_ff @(posedge clk) begin
		if (dp_ctl.mul_en) begin
			prod_s2 <= $signed(a_data) * $signed(b_data);
		end
	end

	// Exact accumulation, seeded with the stored C element.
	always_ff @(posedge clk) begin
		if (dp_ctl.load_acc) begin
			acc_q <= SW'($signed(c_data));
		end else if (dp_ctl.add_en) begin
			acc_q <= acc_q + SW'(prod_s2);
		end
	end

	// The sum fits when every bit above the result's sign bit equals it.
	assign top_bits  = acc_q[SW-1:ACCUM_WIDTH-1];
	assign saturated = !((&top_bits) || !(|top_bits));
	assign result    = saturated ? (acc_q[SW-1] ? NEG_MIN : POS_MAX) :
		acc_q[ACCUM_WIDTH-1:0];

endmodule

// ===== tb/mma_checker.sv =====
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate checker
// Watches the configuration port and the request and response channels of the block,
// keeps its own copy of the operand and accumulator stores, predicts every
// computed C element and compares it with the block's response.
// ----------------------------------------------------------------------------
module mma_checker #(
	parameter int MAX_DIM       = 16,
	parameter int OPERAND_WIDTH = 16,
	parameter int ACCUM_WIDTH   = 48
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration port.
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mma_pkg::PADDR_W-1:0]         paddr,
	input  logic [mma_pkg::PDATA_W-1:0]         pwdata,
	input  logic                                pready,
	// Request channel.
	input  logic                                req_valid,
	input  logic                                req_stall,
	input  logic [1:0]                          action,
	input  logic [mma_pkg::IDX_W-1:0]           row,
	input  logic [mma_pkg::IDX_W-1:0]           col,
	input  logic signed [OPERAND_WIDTH-1:0]     operand_value,
	input  logic signed [ACCUM_WIDTH-1:0]       accum_value,
	// Response channel.
	input  logic                                res_valid,
	input  logic                                res_stall,
	input  logic [mma_pkg::IDX_W-1:0]           out_row,
	input  logic [mma_pkg::IDX_W-1:0]           out_col,
	input  logic signed [ACCUM_WIDTH-1:0]       result,
	input  logic                                saturated,
	// Status towards the testbench top.
	output int                                  mismatch_count,
	output int                                  sums_outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import mma_pkg::*;

	localparam int     DEPTH = MAX_DIM * MAX_DIM;
	localparam longint C_MAX = (longint'(1) <<< (ACCUM_WIDTH - 1)) - 1;
	localparam longint C_MIN = -C_MAX - 1;

	// One predicted response: the element's position, its new value and the clip flag.
	typedef struct packed {
		logic [IDX_W-1:0]       row;
		logic [IDX_W-1:0]       col;
		logic [ACCUM_WIDTH-1:0] sum;
		logic                   sat;
	} c_update_t;

	logic signed [OPERAND_WIDTH-1:0] a_mem [DEPTH];
	logic signed [OPERAND_WIDTH-1:0] b_mem [DEPTH];
	logic signed [ACCUM_WIDTH-1:0]   c_mem [DEPTH];

	logic [CFG_W-1:0] rows_cfg;
	logic [CFG_W-1:0] inner_cfg;
	logic [CFG_W-1:0] cols_cfg;
	logic             transposed_cfg;

	c_update_t pending_sums [$];
	c_update_t head;
	c_update_t fresh;
	int        mismatches;
	int        slot;

	initial begin
		mismatches       = 0;
		mismatch_count   = 0;
		sums_outstanding = 0;
	end

	// Dimension registers above the store size act as the store size.
	function automatic int dim_in_use(input logic [CFG_W-1:0] d);
		return (int'(d) > MAX_DIM) ? MAX_DIM : int'(d);
	endfunction

	// Exact dot product added to the current C element, then clipped once.
	function automatic c_update_t mac_element(input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c);
		longint    acc;
		int        kdim;
		int        k;
		int        b_at;
		c_update_t upd;
		acc  = longint'(c_mem[int'(r) * MAX_DIM + int'(c)]);
		kdim = dim_in_use(inner_cfg);
		for (k = 0; k < kdim; k++) begin
			b_at = transposed_cfg ? int'(c) * MAX_DIM + k : k * MAX_DIM + int'(c);
			acc += longint'(a_mem[int'(r) * MAX_DIM + k]) * longint'(b_mem[b_at]);
		end
		upd.row = r;
		upd.col = c;
		if (acc > C_MAX) begin
			upd.sum = C_MAX[ACCUM_WIDTH-1:0];
			upd.sat = 1'b1;
		end else if (acc < C_MIN) begin
			upd.sum = C_MIN[ACCUM_WIDTH-1:0];
			upd.sat = 1'b1;
		end else begin
			upd.sum = acc[ACCUM_WIDTH-1:0];
			upd.sat = 1'b0;
		end
		return upd;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg       = DIM_RESET;
			inner_cfg      = DIM_RESET;
			cols_cfg       = DIM_RESET;
			transposed_cfg = 1'b0;
			for (slot = 0; slot < DEPTH; slot++)
				c_mem[slot] = '0;
			pending_sums.delete();
		end else begin
			// Responses are compared before this edge's request is predicted.
			if (res_valid && !res_stall) begin
				if (pending_sums.size() == 0) begin
					mismatches++;
					$error("response with no compute request outstanding: row %0d col %0d",
						out_row, out_col);
				end else begin
					head = pending_sums.pop_front();
					if (out_row !== head.row) begin
						mismatches++;
						$error("out_row mismatch: expected %0d actual %0d", head.row, out_row);
					end
					if (out_col !== head.col) begin
						mismatches++;
						$error("out_col mismatch: expected %0d actual %0d", head.col, out_col);
					end
					if (result !== head.sum) begin
						mismatches++;
						$error("result mismatch: expected %h actual %h", head.sum, result);
					end
					if (saturated !== head.sat) begin
						mismatches++;
						$error("saturated mismatch: expected %0b actual %0b", head.sat, saturated);
					end
				end
			end

			// Register writes keep only the low bits that each register holds.
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[PADDR_W-1:2]))
					REG_ROWS_OF_A: begin
						rows_cfg = pwdata[CFG_W-1:0];
					end
					REG_INNER_DIM: begin
						inner_cfg = pwdata[CFG_W-1:0];
					end
					REG_COLS_OF_C: begin
						cols_cfg = pwdata[CFG_W-1:0];
					end
					REG_B_TRANSPOSED: begin
						transposed_cfg = pwdata[0];
					end
					default: begin
					end
				endcase
			end

			// Accepted request: update the stores or predict one C element.
			if (req_valid && !req_stall && int'(row) < MAX_DIM && int'(col) < MAX_DIM) begin
				slot = int'(row) * MAX_DIM + int'(col);
				case (action_t'(action))
					ACT_WRITE_A: begin
						a_mem[slot] = operand_value;
					end
					ACT_WRITE_B: begin
						b_mem[slot] = operand_value;
					end
					ACT_PRELOAD_C: begin
						c_mem[slot] = accum_value;
					end
					ACT_COMPUTE: begin
						if (int'(row) < dim_in_use(rows_cfg) && int'(col) < dim_in_use(cols_cfg)) begin
							fresh = mac_element(row, col);
							c_mem[slot] = fresh.sum;
							pending_sums = {pending_sums, fresh};
						end
					end
					default: begin
					end
				endcase
			end
		end
		mismatch_count   <= mismatches;
		sums_outstanding <= pending_sums.size();
	end

endmodule

// ===== tb/tb_matrix_multiply_accumulate.sv =====
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate testbench
// Drives operand writes, accumulator preloads and compute requests under a
// series of matrix shapes, with random idling on both channels, and lets the
// checker compare every returned C element against its own prediction.
// ----------------------------------------------------------------------------
module tb_matrix_multiply_accumulate;
	timeunit 1ns;
	timeprecision 1ps;

	import mma_pkg::*;

	localparam int MAX_DIM       = 16;
	localparam int OPERAND_WIDTH = 16;
	localparam int ACCUM_WIDTH   = 48;
	localparam int DEPTH         = MAX_DIM * MAX_DIM;
	localparam int DRAIN_CYCLES  = 2 * (MAX_DIM + 5) + 8;
	localparam int LONG_HOLD     = 400;
	localparam int PHASES        = 10;

	localparam logic signed [OPERAND_WIDTH-1:0] OP_MAX = {1'b0, {(OPERAND_WIDTH-1){1'b1}}};
	localparam logic signed [OPERAND_WIDTH-1:0] OP_MIN = {1'b1, {(OPERAND_WIDTH-1){1'b0}}};
	localparam logic signed [ACCUM_WIDTH-1:0]   ACC_MAX = {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
	localparam logic signed [ACCUM_WIDTH-1:0]   ACC_MIN = {1'b1, {(ACCUM_WIDTH-1){1'b0}}};

	logic                              clk = 1'b0;
	logic                              arst_n;
	logic                              psel;
	logic                              penable;
	logic                              pwrite;
	logic [PADDR_W-1:0]                paddr;
	logic [PDATA_W-1:0]                pwdata;
	logic [PDATA_W-1:0]                prdata;
	logic                              pready;
	logic                              req_valid;
	logic                              req_stall;
	action_t                           action;
	logic [IDX_W-1:0]                  row;
	logic [IDX_W-1:0]                  col;
	logic signed [OPERAND_WIDTH-1:0]   operand_value;
	logic signed [ACCUM_WIDTH-1:0]     accum_value;
	logic                              res_valid;
	logic                              res_stall;
	logic [IDX_W-1:0]                  out_row;
	logic [IDX_W-1:0]                  out_col;
	logic signed [ACCUM_WIDTH-1:0]     result;
	logic                              saturated;
	int                                mismatch_count;
	int                                sums_outstanding;

	// Stimulus-side view of the shape registers and of which operands exist.
	logic [CFG_W-1:0] rows_cfg;
	logic [CFG_W-1:0] inner_cfg;
	logic [CFG_W-1:0] cols_cfg;
	logic             transposed_cfg;
	bit               a_written [DEPTH];
	bit               b_written [DEPTH];
	int               requests_sent;
	bit               sender_steady;
	bit               hold_results;

	matrix_multiply_accumulate #(
		.MAX_DIM      (MAX_DIM),
		.OPERAND_WIDTH(OPERAND_WIDTH),
		.ACCUM_WIDTH  (ACCUM_WIDTH)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.action       (action),
		.row          (row),
		.col          (col),
		.operand_value(operand_value),
		.accum_value  (accum_value),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.out_row      (out_row),
		.out_col      (out_col),
		.result       (result),
		.saturated    (saturated)
	);

	mma_checker #(
		.MAX_DIM      (MAX_DIM),
		.OPERAND_WIDTH(OPERAND_WIDTH),
		.ACCUM_WIDTH  (ACCUM_WIDTH)
	) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pready          (pready),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.action          (action),
		.row             (row),
		.col             (col),
		.operand_value   (operand_value),
		.accum_value     (accum_value),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.out_row         (out_row),
		.out_col         (out_col),
		.result          (result),
		.saturated       (saturated),
		.mismatch_count  (mismatch_count),
		.sums_outstanding(sums_outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Hard stop in case the block hangs.
	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int dim_in_use(input logic [CFG_W-1:0] d);
		return (int'(d) > MAX_DIM) ? MAX_DIM : int'(d);
	endfunction

	function automatic logic signed [OPERAND_WIDTH-1:0] rand_operand();
		case ($urandom_range(0, 7))
			0: return OP_MIN;
			1: return OP_MAX;
			2: return OPERAND_WIDTH'($signed($urandom_range(0, 64)) - 32);
			default: return OPERAND_WIDTH'($urandom());
		endcase
	endfunction

	// Preloads lean towards the range ends so that sums clip in both directions.
	function automatic logic signed [ACCUM_WIDTH-1:0] rand_accum();
		case ($urandom_range(0, 7))
			0: return ACC_MAX;
			1: return ACC_MIN;
			2: return ACC_MAX - ACCUM_WIDTH'({$urandom(), $urandom()} & 64'h3_FFFF_FFFF);
			3: return ACC_MIN + ACCUM_WIDTH'({$urandom(), $urandom()} & 64'h3_FFFF_FFFF);
			default: return ACCUM_WIDTH'({$urandom(), $urandom()});
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] rand_dim();
		if ($urandom_range(0, 3) == 0)
			return CFG_W'($urandom_range(0, 31));
		return CFG_W'($urandom_range(1, MAX_DIM));
	endfunction

	// Random pause on the request channel; the caller sits at an accepting edge.
	task automatic request_gap();
		int n;
		n = 0;
		if (!sender_steady) begin
			case ($urandom_range(0, 19))
				0: n = $urandom_range(10, 40);
				1, 2, 3, 4, 5, 6: n = $urandom_range(1, 3);
				default: n = 0;
			endcase
		end
		if (n > 0) begin
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Offer one request, hold it until accepted, then maybe idle.
	task automatic send_request(input action_t act, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic signed [OPERAND_WIDTH-1:0] opv,
			input logic signed [ACCUM_WIDTH-1:0] accv);
		req_valid     <= 1'b1;
		action        <= act;
		row           <= r;
		col           <= c;
		operand_value <= opv;
		accum_value   <= accv;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		requests_sent++;
		if (act == ACT_WRITE_A)
			a_written[int'(r) * MAX_DIM + int'(c)] = 1'b1;
		if (act == ACT_WRITE_B)
			b_written[int'(r) * MAX_DIM + int'(c)] = 1'b1;
		request_gap();
	endtask

	// One register write: setup cycle, access cycle, then back to idle.
	task automatic write_register(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Bits above each register's width carry noise; the block must drop them.
	task automatic set_shape(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] k,
			input logic [CFG_W-1:0] c, input logic t);
		logic [PDATA_W-1:0] word;
		word = $urandom();
		word[CFG_W-1:0] = r;
		write_register(REG_ROWS_OF_A, word);
		word = $urandom();
		word[CFG_W-1:0] = k;
		write_register(REG_INNER_DIM, word);
		word = $urandom();
		word[CFG_W-1:0] = c;
		write_register(REG_COLS_OF_C, word);
		word = $urandom();
		word[0] = t;
		write_register(REG_B_TRANSPOSED, word);
		rows_cfg       = r;
		inner_cfg      = k;
		cols_cfg       = c;
		transposed_cfg = t;
	endtask

	// Hold the sender back until every predicted sum has come back.
	task automatic wait_results_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sums_outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// A compute only reads operands that have been written, so fill the gaps first.
	task automatic fill_operands(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c);
		int               k;
		logic [IDX_W-1:0] br;
		logic [IDX_W-1:0] bc;
		for (k = 0; k < dim_in_use(inner_cfg); k++) begin
			if (!a_written[int'(r) * MAX_DIM + k])
				send_request(ACT_WRITE_A, r, IDX_W'(k), rand_operand(), rand_accum());
			br = transposed_cfg ? c : IDX_W'(k);
			bc = transposed_cfg ? IDX_W'(k) : c;
			if (!b_written[int'(br) * MAX_DIM + int'(bc)])
				send_request(ACT_WRITE_B, br, bc, rand_operand(), rand_accum());
		end
	endtask

	task automatic random_request();
		logic [IDX_W-1:0] r;
		logic [IDX_W-1:0] c;
		int               pick;
		int               rows_eff;
		int               cols_eff;
		r        = IDX_W'($urandom());
		c        = IDX_W'($urandom());
		pick     = $urandom_range(0, 19);
		rows_eff = dim_in_use(rows_cfg);
		cols_eff = dim_in_use(cols_cfg);
		if (pick < 4) begin
			send_request(ACT_WRITE_A, r, c, rand_operand(), rand_accum());
		end else if (pick < 8) begin
			send_request(ACT_WRITE_B, r, c, rand_operand(), rand_accum());
		end else if (pick < 11) begin
			send_request(ACT_PRELOAD_C, r, c, rand_operand(), rand_accum());
		end else begin
			// Mostly elements in use, now and then one that must be ignored.
			if ($urandom_range(0, 9) != 0 && rows_eff > 0 && cols_eff > 0) begin
				r = IDX_W'($urandom_range(0, rows_eff - 1));
				c = IDX_W'($urandom_range(0, cols_eff - 1));
			end
			if (int'(r) < rows_eff && int'(c) < cols_eff)
				fill_operands(r, c);
			send_request(ACT_COMPUTE, r, c, rand_operand(), rand_accum());
		end
	endtask

	// Result receiver: random stalls, quiet stretches and one long hold-off.
	initial begin : receiver
		int stall_left;
		int quiet_left;
		stall_left = 0;
		quiet_left = 0;
		res_stall  = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_results) begin
				res_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_results = 1'b0;
			end else if (quiet_left > 0) begin
				res_stall <= 1'b0;
				quiet_left--;
			end else if (stall_left > 0) begin
				res_stall <= 1'b1;
				stall_left--;
			end else begin
				res_stall <= 1'b0;
				case ($urandom_range(0, 9))
					0: quiet_left = $urandom_range(20, 200);
					1, 2, 3: stall_left = $urandom_range(1, 3);
					4: stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
						: $urandom_range(4, 10);
					default: begin
					end
				endcase
			end
		end
	end

	initial begin : stimulus
		int phase;
		int phase_items;
		int phase_end;
		int i;
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		req_valid      = 1'b0;
		action         = ACT_WRITE_A;
		row            = '0;
		col            = '0;
		operand_value  = '0;
		accum_value    = '0;
		rows_cfg       = DIM_RESET;
		inner_cfg      = DIM_RESET;
		cols_cfg       = DIM_RESET;
		transposed_cfg = 1'b0;
		requests_sent  = 0;
		sender_steady  = 1'b0;
		hold_results   = 1'b0;
		for (i = 0; i < DEPTH; i++) begin
			a_written[i] = 1'b0;
			b_written[i] = 1'b0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: 2x2 operands at the range ends, clipping both ways,
		// requests outside C in use and the corner indexes of the stores.
		set_shape(5'd2, 5'd2, 5'd2, 1'b0);
		send_request(ACT_WRITE_A, 4'd0, 4'd0, OP_MIN, ACC_MAX);
		send_request(ACT_WRITE_A, 4'd0, 4'd1, OP_MAX, ACC_MIN);
		send_request(ACT_WRITE_A, 4'd1, 4'd0, OP_MIN, '0);
		send_request(ACT_WRITE_A, 4'd1, 4'd1, OP_MIN, '1);
		send_request(ACT_WRITE_B, 4'd0, 4'd0, OP_MIN, '0);
		send_request(ACT_WRITE_B, 4'd1, 4'd0, OP_MAX, '0);
		send_request(ACT_WRITE_B, 4'd0, 4'd1, OP_MAX, '0);
		send_request(ACT_WRITE_B, 4'd1, 4'd1, OP_MIN, '0);
		send_request(ACT_PRELOAD_C, 4'd0, 4'd0, '0, ACC_MAX);
		send_request(ACT_COMPUTE, 4'd0, 4'd0, '1, '1);
		send_request(ACT_PRELOAD_C, 4'd0, 4'd1, '0, ACC_MIN);
		send_request(ACT_COMPUTE, 4'd0, 4'd1, '0, '0);
		send_request(ACT_COMPUTE, 4'd1, 4'd1, '0, '0);
		send_request(ACT_COMPUTE, 4'd0, 4'd0, '0, '0);
		send_request(ACT_COMPUTE, 4'd15, 4'd0, '0, '0);
		send_request(ACT_COMPUTE, 4'd0, 4'd15, '0, '0);
		send_request(ACT_WRITE_A, 4'd15, 4'd15, OP_MAX, '1);
		send_request(ACT_WRITE_B, 4'd15, 4'd15, OP_MIN, '1);
		send_request(ACT_PRELOAD_C, 4'd15, 4'd15, '1, ACC_MIN);
		send_request(ACT_PRELOAD_C, 4'd1, 4'd0, '0, rand_accum());
		send_request(ACT_COMPUTE, 4'd1, 4'd0, '0, '0);
		wait_results_drained();

		// Random phases, each under its own shape.
		for (phase = 1; phase <= PHASES; phase++) begin
			case (phase)
				1: begin
					set_shape(5'd16, 5'd16, 5'd16, 1'b0);
					phase_items = 350;
				end
				2: begin
					set_shape(5'd1, 5'd1, 5'd1, 1'b0);
					phase_items = 120;
				end
				3: begin
					set_shape(5'd16, 5'd16, 5'd16, 1'b1);
					phase_items = 300;
				end
				4: begin
					// No row of C in use: every compute is dropped.
					set_shape(5'd0, 5'd5, 5'd7, 1'b0);
					phase_items = 60;
				end
				5: begin
					// Empty inner dimension: C comes back unchanged.
					set_shape(5'd6, 5'd0, 5'd9, 1'b1);
					phase_items = 80;
				end
				6: begin
					// Shape registers beyond the store size.
					set_shape(5'd31, 5'd17, 5'd20, 1'b0);
					phase_items = 250;
				end
				default: begin
					set_shape(rand_dim(), rand_dim(), rand_dim(), 1'($urandom()));
					phase_items = 180;
				end
			endcase
			sender_steady = ($urandom_range(0, 3) == 0);
			// The big transposed phase starts with a long receiver hold-off.
			if (phase == 3) begin
				sender_steady = 1'b1;
				hold_results  = 1'b1;
			end
			phase_end = requests_sent + phase_items;
			while (requests_sent < phase_end)
				random_request();
			wait_results_drained();
		end

		if (mismatch_count == 0 && sums_outstanding == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
